// ----- rtl/core/pli_pkg.sv -----
// Shared constants and types of the piecewise linear interpolator.
`default_nettype none

package pli_pkg;

   localparam int MAX_NODES  = 64;
   localparam int NODE_IDX_W = $clog2(MAX_NODES);
   localparam int COUNT_W    = 7;
   localparam int TOL_W      = 16;
   localparam int DATA_W     = 32;
   localparam int ALU_W      = DATA_W + 2;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int DIV_STEPS  = DATA_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 1'd1;

   typedef struct packed {
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
      logic             subtract;
   } alu_req_type;

endpackage

`default_nettype wire

// ----- rtl/core/pli_alu.sv -----
// Shared add/subtract unit used for scan, multiply, divide and final sum.
`default_nettype none

module pli_alu (
   input  pli_pkg::alu_req_type          alu_req,
   output logic [pli_pkg::ALU_W-1:0]     alu_sum
);
   import pli_pkg::*;

   logic [ALU_W-1:0] op_b_eff;

   // Invert and add one to subtract.
   assign op_b_eff = alu_req.subtract ? ~alu_req.op_b : alu_req.op_b;
   assign alu_sum  = alu_req.op_a + op_b_eff + {{(ALU_W-1){1'b0}}, alu_req.subtract};

endmodule

`default_nettype wire

// ----- rtl/core/pli_node_mem.sv -----
// Node table: position and value memories, one write and one registered read port.
`default_nettype none

module pli_node_mem (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [pli_pkg::NODE_IDX_W-1:0]     wr_addr,
   input  logic [pli_pkg::DATA_W-1:0]         wr_position,
   input  logic [pli_pkg::DATA_W-1:0]         wr_value,
   input  logic [pli_pkg::NODE_IDX_W-1:0]     rd_addr,
   output logic [pli_pkg::DATA_W-1:0]         rd_position,
   output logic [pli_pkg::DATA_W-1:0]         rd_value
);
   import pli_pkg::*;

   logic [DATA_W-1:0] position_mem [MAX_NODES];
   logic [DATA_W-1:0] value_mem    [MAX_NODES];
   logic [DATA_W-1:0] rd_position_ff;
   logic [DATA_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         position_mem[wr_addr] <= wr_position;
         value_mem[wr_addr]    <= wr_value;
      end
      rd_position_ff <= position_mem[rd_addr];
      rd_value_ff    <= value_mem[rd_addr];
   end

   assign rd_position = rd_position_ff;
   assign rd_value    = rd_value_ff;

endmodule

`default_nettype wire

// ----- rtl/core/piecewise_linear_interpolator_top.sv -----
// Top level of the piecewise linear interpolator: sequencer, node table and shared adder.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------------
//   req_    | in        | req_valid / req_stall      | command, node_index, node_position,
//           |           |                            | node_value, query_position
//   rsp_    | out       | rsp_valid / rsp_stall      | value, failed
//   csr_    | in        | csr_write_enable           | csr_index, csr_write_data
//
// A load transaction writes the table in the cycle it is accepted; the next one may follow at once.
// A query holds req_stall high until the sequencer is back in idle, whether it ends on a node
// or a bound or interpolates; it scans k <= node_count - 1 intervals. The one 34-bit
// adder paces this: one interval per cycle, then 32 shift-add and 32 shift-subtract steps.
// Reset (synchronous, active high) clears the sequencer, the output valid and the registers to
// node_count = 1 and tolerance = 0; the node table is not cleared.
// A finished result waits in its state while rsp_stall holds the output register full.
`default_nettype none

module piecewise_linear_interpolator_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [pli_pkg::NODE_IDX_W-1:0]       req_node_index,
   input  logic signed [pli_pkg::DATA_W-1:0]    req_node_position,
   input  logic signed [pli_pkg::DATA_W-1:0]    req_node_value,
   input  logic signed [pli_pkg::DATA_W-1:0]    req_query_position,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pli_pkg::DATA_W-1:0]    rsp_value,
   output logic                                 rsp_failed,
   // configuration port
   input  logic                                 csr_write_enable,
   input  logic [pli_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pli_pkg::CSR_DATA_W-1:0]       csr_write_data
);
   import pli_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_FIRST  = 10'b0000000010,
      ST_SCAN   = 10'b0000000100,
      ST_SPAN   = 10'b0000001000,
      ST_DELTA  = 10'b0000010000,
      ST_MAG    = 10'b0000100000,
      ST_MUL    = 10'b0001000000,
      ST_DIV    = 10'b0010000000,
      ST_FINAL  = 10'b0100000000,
      ST_RESULT = 10'b1000000000
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   // control registers
   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     node_count_ff;
   logic [TOL_W-1:0]       tolerance_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [NODE_IDX_W-1:0]  index_ff, index_in;

   // payload registers
   logic [DATA_W-1:0]      x_ff, x_in;
   logic [ALU_W-1:0]       da_ff, da_in;
   logic [ALU_W-1:0]       db_ff, db_in;
   logic [DATA_W-1:0]      va_ff, va_in;
   logic [DATA_W-1:0]      vb_ff, vb_in;
   logic [DATA_W-1:0]      span_ff, span_in;
   logic [ALU_W-1:0]       delta_ff, delta_in;
   logic [DATA_W-1:0]      mag_ff, mag_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DATA_W-1:0]      res_value_ff, res_value_in;
   logic                   res_failed_ff, res_failed_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                   rsp_failed_ff, rsp_failed_in;

   // datapath
   alu_req_type            alu_req;
   logic [ALU_W-1:0]       alu_sum;
   logic [NODE_IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0]      mem_position;
   logic [DATA_W-1:0]      mem_value;
   logic                   load_accept;
   logic [COUNT_W-1:0]     n_eff;
   logic [COUNT_W-1:0]     last_index;
   logic                   out_free;
   logic                   first_iv;
   logic                   last_iv;
   logic                   delta_neg;
   logic signed [ALU_W-1:0] da_s, db_s, eps_s, neg_eps_s;
   logic                   da_near, db_near;

   pli_alu u_alu (
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   pli_node_mem u_mem (
      .clock       (clock),
      .wr_en       (load_accept),
      .wr_addr     (req_node_index),
      .wr_position (req_node_position),
      .wr_value    (req_node_value),
      .rd_addr     (rd_addr),
      .rd_position (mem_position),
      .rd_value    (mem_value)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign load_accept = req_valid && !req_stall && (req_command == CMD_LOAD);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Clamp node count: zero counts as one node, saturate at the table depth.
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = COUNT_W'(1);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         n_eff = COUNT_W'(MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end
   assign last_index = n_eff - COUNT_W'(1);

   // Interval tests: da = x - p[index-1] held, db = x - p[index] fresh from the adder.
   assign first_iv  = (index_ff == NODE_IDX_W'(1));
   assign last_iv   = ({1'b0, index_ff} == last_index);
   assign da_s      = $signed(da_ff);
   assign db_s      = $signed(alu_sum);
   assign eps_s     = $signed({{(ALU_W-TOL_W){1'b0}}, tolerance_ff});
   assign neg_eps_s = -eps_s;
   assign da_near   = (da_s < eps_s) && (da_s > neg_eps_s);
   assign db_near   = (db_s < eps_s) && (db_s > neg_eps_s);
   assign delta_neg = delta_ff[ALU_W-1];

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      index_in      = index_ff;
      x_in          = x_ff;
      da_in         = da_ff;
      db_in         = db_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      span_in       = span_ff;
      delta_in      = delta_ff;
      mag_in        = mag_ff;
      prod_in       = prod_ff;
      res_value_in  = res_value_ff;
      res_failed_in = res_failed_ff;
      rd_addr       = index_ff;
      // default adder use: x minus the node position just read
      alu_req.op_a     = {{2{x_ff[DATA_W-1]}}, x_ff};
      alu_req.op_b     = {{2{mem_position[DATA_W-1]}}, mem_position};
      alu_req.subtract = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_valid && req_command == CMD_QUERY) begin
               x_in     = req_query_position;
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            rd_addr = NODE_IDX_W'(1);
            if (n_eff == COUNT_W'(1)) begin
               res_value_in  = mem_value;
               res_failed_in = 1'b0;
               state_in      = ST_RESULT;
            end else begin
               da_in    = alu_sum;
               va_in    = mem_value;
               index_in = NODE_IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr       = index_ff + NODE_IDX_W'(1);
            res_failed_in = 1'b0;
            if (first_iv && da_s <= eps_s) begin
               res_value_in = va_ff;
               state_in     = ST_RESULT;
            end else if (last_iv && db_s >= eps_s) begin
               res_value_in = mem_value;
               state_in     = ST_RESULT;
            end else if (da_near) begin
               res_value_in = va_ff;
               state_in     = ST_RESULT;
            end else if (db_near) begin
               res_value_in = mem_value;
               state_in     = ST_RESULT;
            end else if (da_s > 0 && db_s < 0) begin
               vb_in    = mem_value;
               db_in    = alu_sum;
               state_in = ST_SPAN;
            end else if (last_iv) begin
               res_value_in  = '0;
               res_failed_in = 1'b1;
               state_in      = ST_RESULT;
            end else begin
               // advance to the next interval
               da_in    = alu_sum;
               va_in    = mem_value;
               index_in = index_ff + NODE_IDX_W'(1);
            end
         end
         ST_SPAN: begin
            alu_req.op_a = da_ff;
            alu_req.op_b = db_ff;
            span_in      = alu_sum[DATA_W-1:0];
            state_in     = ST_DELTA;
         end
         ST_DELTA: begin
            alu_req.op_a = {{2{vb_ff[DATA_W-1]}}, vb_ff};
            alu_req.op_b = {{2{va_ff[DATA_W-1]}}, va_ff};
            delta_in     = alu_sum;
            state_in     = ST_MAG;
         end
         ST_MAG: begin
            alu_req.op_a     = delta_neg ? '0 : delta_ff;
            alu_req.op_b     = delta_neg ? delta_ff : '0;
            alu_req.subtract = delta_neg;
            mag_in           = alu_sum[DATA_W-1:0];
            prod_in          = {{DATA_W{1'b0}}, da_ff[DATA_W-1:0]};
            step_in          = '0;
            state_in         = ST_MUL;
         end
         ST_MUL: begin
            alu_req.op_a     = {2'b00, prod_ff[PROD_W-1:DATA_W]};
            alu_req.op_b     = {2'b00, mag_ff};
            alu_req.subtract = 1'b0;
            if (prod_ff[0]) begin
               prod_in = {alu_sum[DATA_W:0], prod_ff[DATA_W-1:1]};
            end else begin
               prod_in = {1'b0, prod_ff[PROD_W-1:1]};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            alu_req.op_a = {1'b0, prod_ff[PROD_W-1:DATA_W], prod_ff[DATA_W-1]};
            alu_req.op_b = {2'b00, span_ff};
            if (!alu_sum[ALU_W-1]) begin
               prod_in = {alu_sum[DATA_W-1:0], prod_ff[DATA_W-2:0], 1'b1};
            end else begin
               prod_in = {prod_ff[PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            // step from the left node toward the right one by the quotient
            alu_req.op_a     = {{2{va_ff[DATA_W-1]}}, va_ff};
            alu_req.op_b     = {2'b00, prod_ff[DATA_W-1:0]};
            alu_req.subtract = delta_neg;
            res_value_in     = alu_sum[DATA_W-1:0];
            res_failed_in    = 1'b0;
            state_in         = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load when the result is ready and the register is free, drop on take.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_failed_in = rsp_failed_ff;
      if (state_ff == ST_RESULT && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_failed_in = res_failed_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= COUNT_W'(1);
         tolerance_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= '0;
         index_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         index_ff     <= index_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_NODE_COUNT: node_count_ff <= csr_write_data[COUNT_W-1:0];
               CSR_TOLERANCE:  tolerance_ff  <= csr_write_data[TOL_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      da_ff         <= da_in;
      db_ff         <= db_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      span_ff       <= span_in;
      delta_ff      <= delta_in;
      mag_ff        <= mag_in;
      prod_ff       <= prod_in;
      res_value_ff  <= res_value_in;
      res_failed_ff <= res_failed_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_failed_ff <= rsp_failed_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_failed = rsp_failed_ff;

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_value == '0)
      else $error("failed result carries a nonzero value");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && req_valid && req_command == CMD_QUERY |=> state_ff == ST_FIRST)
      else $error("accepted query did not start the scan");

   a_mul_to_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL && step_ff == STEP_LAST |=> state_ff == ST_DIV && step_ff == '0)
      else $error("multiply did not hand over to divide after its last step");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESULT && rsp_valid_ff && rsp_stall |=> state_ff == ST_RESULT)
      else $error("result left its state while the output register was full");
`endif

endmodule

`default_nettype wire
